/* src/bcr_pkg.sv */
// Shared widths, codes and reset values for the bilinear channel resampler.
// Depends on nothing; every other file in src imports it.
package bcr_pkg;

   localparam int OPCODE_W    = 1;
   localparam int POS_W       = 12;
   localparam int TEXEL_W     = 8;
   localparam int SAMPLE_W    = 8;
   localparam int SRC_SIDE_W  = 9;
   localparam int TGT_SIDE_W  = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam int MAX_SOURCE_SIDE_DEFAULT = 256;
   localparam int FRACTION_BITS_DEFAULT   = 8;

   localparam logic [SRC_SIDE_W-1:0] SOURCE_WIDTH_RESET  = 9'd256;
   localparam logic [SRC_SIDE_W-1:0] SOURCE_HEIGHT_RESET = 9'd256;
   localparam logic [TGT_SIDE_W-1:0] TARGET_WIDTH_RESET  = 13'd256;
   localparam logic [TGT_SIDE_W-1:0] TARGET_HEIGHT_RESET = 13'd256;
   localparam logic                  ROUND_NEAREST_RESET = 1'b0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_WIDTH  = 3'd0,
      CSR_SOURCE_HEIGHT = 3'd1,
      CSR_TARGET_WIDTH  = 3'd2,
      CSR_TARGET_HEIGHT = 3'd3,
      CSR_ROUND_NEAREST = 3'd4
   } csr_index_type;

endpackage

/* src/bcr_req_if.sv */
// Request channel of the resampler: texel writes and sample requests.
// Depends on bcr_pkg for field widths.
interface bcr_req_if import bcr_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    pos_x;
   logic [POS_W-1:0]    pos_y;
   logic [TEXEL_W-1:0]  texel;

   modport source (output valid, output opcode, output pos_x, output pos_y, output texel,
                   input ready);
   modport sink   (input valid, input opcode, input pos_x, input pos_y, input texel,
                   output ready);

endinterface

/* src/bcr_rsp_if.sv */
// Response channel of the resampler: one interpolated sample per sample request.
// Depends on bcr_pkg for field widths.
interface bcr_rsp_if import bcr_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);

endinterface

/* src/bilinear_channel_resampler.sv */
// channel   direction  handshake        payload
// req_ch    in         valid / ready    opcode, pos_x, pos_y, texel
// rsp_ch    out        valid / ready    sample
// csr_*     in         csr_wr_en only   csr_index, csr_wdata
//
// Bilinear resampler top level: fixed-point position mapping, banked texel store,
// two-pass interpolation. Depends on bcr_pkg, bcr_req_if and bcr_rsp_if.
//
// One word is taken every cycle unless rsp_ch stalls. Positions are mapped by a
// restoring divider, one quotient bit per stage. Texel writes take effect in order
// at the store stage and give no response. Reset is synchronous and clears the
// valid bits and the configuration registers; the data registers and the store
// are not cleared. A stall on rsp_ch freezes every stage and drops req_ch.ready
// in the same cycle.
module bilinear_channel_resampler import bcr_pkg::*; #(
   parameter int MAX_SOURCE_SIDE = MAX_SOURCE_SIDE_DEFAULT,
   parameter int FRACTION_BITS   = FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   bcr_req_if.sink                req_ch,
   bcr_rsp_if.source              rsp_ch
);

   localparam int F         = FRACTION_BITS;
   localparam int IDX_W     = (MAX_SOURCE_SIDE > 2) ? $clog2(MAX_SOURCE_SIDE) : 1;
   localparam int HALF_W    = (IDX_W > 1) ? IDX_W - 1 : 1;
   localparam int ADDR_W    = 2 * HALF_W;
   localparam int BANKS     = 4;
   localparam int BANK_DEPTH = 1 << ADDR_W;
   localparam int PROD_W    = POS_W + SRC_SIDE_W;
   localparam int NUM_W     = PROD_W + F;
   localparam int WHOLE_W   = NUM_W - F;
   localparam int DIV_W     = TGT_SIDE_W;
   localparam int DV_STAGES = NUM_W + 1;
   localparam int TOP_W     = TEXEL_W + F;
   localparam int LW        = TEXEL_W + F + 2;
   localparam int MIX_W     = TEXEL_W + 2 * F;
   localparam int VW        = MIX_W + 2;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [NUM_W-1:0] nq;
   } div_step_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                wr_ok;
      logic [1:0]          wr_bank;
      logic [ADDR_W-1:0]   wr_addr;
      logic [TEXEL_W-1:0]  texel;
      logic [NUM_W-1:0]    nq_x;
      logic [NUM_W-1:0]    nq_y;
      logic [DIV_W-1:0]    rem_x;
      logic [DIV_W-1:0]    rem_y;
   } dv_word_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]             op;
      logic                            wr_ok;
      logic [1:0]                      wr_bank;
      logic [ADDR_W-1:0]               wr_addr;
      logic [TEXEL_W-1:0]              texel;
      logic [BANKS-1:0][ADDR_W-1:0]    rd_addr;
      logic [IDX_W-1:0]                x0;
      logic [IDX_W-1:0]                y0;
      logic                            px;
      logic                            cx;
      logic                            py;
      logic                            cy;
      logic [F-1:0]                    fx;
      logic [F-1:0]                    fy;
   } ma_word_type;

   typedef struct packed {
      logic         px;
      logic         cx;
      logic         py;
      logic         cy;
      logic [F-1:0] fx;
      logic [F-1:0] fy;
   } rd_word_type;

   function automatic div_step_type div_step(input logic [DIV_W-1:0] rem,
                                             input logic [NUM_W-1:0] nq,
                                             input logic [DIV_W-1:0] dv);
      logic [DIV_W:0] r2;
      logic           ge;
      div_step_type   s;
      r2    = {rem, nq[NUM_W-1]};
      ge    = (r2 >= {1'b0, dv});
      s.rem = ge ? DIV_W'(r2 - {1'b0, dv}) : r2[DIV_W-1:0];
      s.nq  = {nq[NUM_W-2:0], ge};
      return s;
   endfunction

   function automatic dv_word_type dv_advance(input dv_word_type w,
                                              input logic [DIV_W-1:0] dvx,
                                              input logic [DIV_W-1:0] dvy);
      div_step_type sx;
      div_step_type sy;
      dv_word_type  o;
      sx      = div_step(w.rem_x, w.nq_x, dvx);
      sy      = div_step(w.rem_y, w.nq_y, dvy);
      o       = w;
      o.nq_x  = sx.nq;
      o.rem_x = sx.rem;
      o.nq_y  = sy.nq;
      o.rem_y = sy.rem;
      return o;
   endfunction

   // configuration registers
   logic [SRC_SIDE_W-1:0] src_w_ff, src_h_ff;
   logic [TGT_SIDE_W-1:0] tgt_w_ff, tgt_h_ff;
   logic                  rnd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SOURCE_WIDTH_RESET;
         src_h_ff <= SOURCE_HEIGHT_RESET;
         tgt_w_ff <= TARGET_WIDTH_RESET;
         tgt_h_ff <= TARGET_HEIGHT_RESET;
         rnd_ff   <= ROUND_NEAREST_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_ff <= csr_wdata[SRC_SIDE_W-1:0];
            CSR_SOURCE_HEIGHT: src_h_ff <= csr_wdata[SRC_SIDE_W-1:0];
            CSR_TARGET_WIDTH:  tgt_w_ff <= csr_wdata[TGT_SIDE_W-1:0];
            CSR_TARGET_HEIGHT: tgt_h_ff <= csr_wdata[TGT_SIDE_W-1:0];
            CSR_ROUND_NEAREST: rnd_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // last index and divisor of each axis
   logic [SRC_SIDE_W-1:0] last_x, last_y;
   logic [DIV_W-1:0]      div_x, div_y;

   always_comb begin
      if (src_w_ff == '0)                      last_x = '0;
      else if (int'(src_w_ff) > MAX_SOURCE_SIDE) last_x = SRC_SIDE_W'(MAX_SOURCE_SIDE - 1);
      else                                     last_x = src_w_ff - SRC_SIDE_W'(1);
      if (src_h_ff == '0)                      last_y = '0;
      else if (int'(src_h_ff) > MAX_SOURCE_SIDE) last_y = SRC_SIDE_W'(MAX_SOURCE_SIDE - 1);
      else                                     last_y = src_h_ff - SRC_SIDE_W'(1);
      div_x = (tgt_w_ff >= DIV_W'(2)) ? tgt_w_ff - DIV_W'(1) : DIV_W'(1);
      div_y = (tgt_h_ff >= DIV_W'(2)) ? tgt_h_ff - DIV_W'(1) : DIV_W'(1);
   end

   // pipeline control
   logic out_valid_ff;
   logic pipe_en;

   assign pipe_en      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = pipe_en;

   // entry and divider stages
   logic        dv_valid_ff [DV_STAGES];
   dv_word_type dv_ff       [DV_STAGES];
   dv_word_type dv_in       [DV_STAGES];
   dv_word_type dv_entry;
   logic [PROD_W-1:0] prod_x, prod_y;
   logic [POS_W-1:0]  half_px, half_py;

   always_comb begin
      prod_x  = req_ch.pos_x * last_x;
      prod_y  = req_ch.pos_y * last_y;
      half_px = req_ch.pos_x >> 1;
      half_py = req_ch.pos_y >> 1;
      dv_entry.op      = req_ch.opcode;
      dv_entry.wr_ok   = (int'(req_ch.pos_x) < MAX_SOURCE_SIDE) &&
                         (int'(req_ch.pos_y) < MAX_SOURCE_SIDE);
      dv_entry.wr_bank = {req_ch.pos_y[0], req_ch.pos_x[0]};
      dv_entry.wr_addr = {HALF_W'(half_py), HALF_W'(half_px)};
      dv_entry.texel   = req_ch.texel;
      dv_entry.nq_x    = {prod_x, {F{1'b0}}};
      dv_entry.nq_y    = {prod_y, {F{1'b0}}};
      dv_entry.rem_x   = '0;
      dv_entry.rem_y   = '0;
   end

   assign dv_in[0] = dv_entry;

   for (genvar k = 1; k < DV_STAGES; k++) begin : g_div
      assign dv_in[k] = dv_advance(dv_ff[k-1], div_x, div_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DV_STAGES; k++) dv_valid_ff[k] <= 1'b0;
      end else if (pipe_en) begin
         dv_valid_ff[0] <= req_ch.valid;
         for (int k = 1; k < DV_STAGES; k++) dv_valid_ff[k] <= dv_valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k < DV_STAGES; k++) dv_ff[k] <= dv_in[k];
      end
   end

   // map stage: neighbour indices, fractions and bank addresses
   dv_word_type       dq;
   logic [WHOLE_W-1:0] whole_x, whole_y;
   logic [IDX_W-1:0]   hx, hy;
   logic [HALF_W-1:0]  xo_idx, xe_idx, yo_idx, ye_idx;
   logic               ma_valid_ff, ma_valid_in;
   ma_word_type        ma_ff, ma_in;

   always_comb begin
      dq       = dv_ff[DV_STAGES-1];
      whole_x  = WHOLE_W'(dq.nq_x >> F);
      whole_y  = WHOLE_W'(dq.nq_y >> F);
      ma_in.op      = dq.op;
      ma_in.wr_ok   = dq.wr_ok;
      ma_in.wr_bank = dq.wr_bank;
      ma_in.wr_addr = dq.wr_addr;
      ma_in.texel   = dq.texel;
      ma_in.cx = (whole_x >= WHOLE_W'(last_x));
      ma_in.cy = (whole_y >= WHOLE_W'(last_y));
      ma_in.x0 = ma_in.cx ? IDX_W'(last_x) : IDX_W'(whole_x);
      ma_in.y0 = ma_in.cy ? IDX_W'(last_y) : IDX_W'(whole_y);
      ma_in.fx = ma_in.cx ? '0 : dq.nq_x[F-1:0];
      ma_in.fy = ma_in.cy ? '0 : dq.nq_y[F-1:0];
      ma_in.px = ma_in.x0[0];
      ma_in.py = ma_in.y0[0];
      hx     = ma_in.x0 >> 1;
      hy     = ma_in.y0 >> 1;
      xo_idx = HALF_W'(hx);
      yo_idx = HALF_W'(hy);
      xe_idx = ma_in.px ? HALF_W'(hx + IDX_W'(1)) : xo_idx;
      ye_idx = ma_in.py ? HALF_W'(hy + IDX_W'(1)) : yo_idx;
      for (int b = 0; b < BANKS; b++) begin
         ma_in.rd_addr[b] = {(b[1] ? yo_idx : ye_idx), (b[0] ? xo_idx : xe_idx)};
      end
      ma_valid_in = dv_valid_ff[DV_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (reset)        ma_valid_ff <= 1'b0;
      else if (pipe_en) ma_valid_ff <= ma_valid_in;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) ma_ff <= ma_in;
   end

   // banked texel store, one bank per column and row parity
   logic [TEXEL_W-1:0] bank_mem   [BANKS][BANK_DEPTH];
   logic [TEXEL_W-1:0] bank_rd_ff [BANKS];
   logic [BANKS-1:0]   wr_hit;

   always_comb begin
      for (int b = 0; b < BANKS; b++) begin
         wr_hit[b] = ma_valid_ff && (ma_ff.op == OP_WRITE) && ma_ff.wr_ok &&
                     (ma_ff.wr_bank == 2'(b));
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int b = 0; b < BANKS; b++) begin
            if (wr_hit[b]) bank_mem[b][ma_ff.wr_addr] <= ma_ff.texel;
            bank_rd_ff[b] <= bank_mem[b][ma_ff.rd_addr[b]];
         end
      end
   end

   logic        rd_valid_ff, rd_valid_in;
   rd_word_type rd_ff, rd_in;

   always_comb begin
      rd_valid_in = ma_valid_ff && (ma_ff.op == OP_SAMPLE);
      rd_in.px    = ma_ff.px;
      rd_in.cx    = ma_ff.cx;
      rd_in.py    = ma_ff.py;
      rd_in.cy    = ma_ff.cy;
      rd_in.fx    = ma_ff.fx;
      rd_in.fy    = ma_ff.fy;
   end

   always_ff @(posedge clock) begin
      if (reset)        rd_valid_ff <= 1'b0;
      else if (pipe_en) rd_valid_ff <= rd_valid_in;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) rd_ff <= rd_in;
   end

   // horizontal pass
   logic               x1b, y1b;
   logic [TEXEL_W-1:0] t00, t10, t01, t11;
   logic signed [TEXEL_W:0] d_top, d_bot;
   logic signed [F:0]       fx_s;
   logic signed [LW-1:0]    top_full, bot_full;
   logic                    h_valid_ff;
   logic [TOP_W-1:0]        h_top_ff, h_top_in, h_bot_ff, h_bot_in;
   logic [F-1:0]            h_fy_ff;

   always_comb begin
      x1b   = rd_ff.cx ? rd_ff.px : !rd_ff.px;
      y1b   = rd_ff.cy ? rd_ff.py : !rd_ff.py;
      t00   = bank_rd_ff[{rd_ff.py, rd_ff.px}];
      t10   = bank_rd_ff[{rd_ff.py, x1b}];
      t01   = bank_rd_ff[{y1b, rd_ff.px}];
      t11   = bank_rd_ff[{y1b, x1b}];
      d_top = $signed({1'b0, t10}) - $signed({1'b0, t00});
      d_bot = $signed({1'b0, t11}) - $signed({1'b0, t01});
      fx_s  = $signed({1'b0, rd_ff.fx});
      top_full = $signed({2'b00, t00, {F{1'b0}}}) + d_top * fx_s;
      bot_full = $signed({2'b00, t01, {F{1'b0}}}) + d_bot * fx_s;
      h_top_in = top_full[TOP_W-1:0];
      h_bot_in = bot_full[TOP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset)        h_valid_ff <= 1'b0;
      else if (pipe_en) h_valid_ff <= rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         h_top_ff <= h_top_in;
         h_bot_ff <= h_bot_in;
         h_fy_ff  <= rd_ff.fy;
      end
   end

   // vertical pass
   logic signed [TOP_W:0] d_mix;
   logic signed [F:0]     fy_s;
   logic signed [VW-1:0]  mix_full;
   logic                  v_valid_ff;
   logic [MIX_W-1:0]      v_mix_ff, v_mix_in;

   always_comb begin
      d_mix    = $signed({1'b0, h_bot_ff}) - $signed({1'b0, h_top_ff});
      fy_s     = $signed({1'b0, h_fy_ff});
      mix_full = $signed({2'b00, h_top_ff, {F{1'b0}}}) + d_mix * fy_s;
      v_mix_in = mix_full[VW-1] ? '0 : mix_full[MIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset)        v_valid_ff <= 1'b0;
      else if (pipe_en) v_valid_ff <= h_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) v_mix_ff <= v_mix_in;
   end

   // round to nearest when enabled, saturate and hold for the response channel
   logic [MIX_W:0]      rounded;
   logic [TEXEL_W:0]    r_whole;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;

   always_comb begin
      rounded   = {1'b0, v_mix_ff} +
                  (rnd_ff ? (MIX_W+1)'(1) << (2 * F - 1) : '0);
      r_whole   = rounded[MIX_W:2*F];
      sample_in = r_whole[TEXEL_W] ? '1 : r_whole[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset)        out_valid_ff <= 1'b0;
      else if (pipe_en) out_valid_ff <= v_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) sample_ff <= sample_in;
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.sample = sample_ff;

`ifndef SYNTHESIS
   a_write_gives_no_sample: assert property (@(posedge clock) disable iff (reset)
      ma_valid_ff && (ma_ff.op == OP_WRITE) && pipe_en |=> !rd_valid_ff)
      else $error("texel write reached the interpolation stages");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      ma_valid_ff && (ma_ff.op == OP_SAMPLE) |->
         ({3'b000, ma_ff.x0} <= (IDX_W+3)'(last_x)) &&
         ({3'b000, ma_ff.y0} <= (IDX_W+3)'(last_y)))
      else $error("neighbour index beyond the last source texel");

   a_reset_flushes: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !rd_valid_ff && !ma_valid_ff)
      else $error("pipeline holds a word after reset");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking bench for bilinear_channel_resampler: texel writes, samples and
// register settings against a bit-exact fixed-point predictor of the scaler.
// Depends on bcr_pkg, bcr_req_if, bcr_rsp_if and the block itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bcr_pkg::*;

   localparam int     SIDE        = MAX_SOURCE_SIDE_DEFAULT;
   localparam int     FRAC        = FRACTION_BITS_DEFAULT;
   localparam longint ONE         = longint'(1) << FRAC;
   localparam int     PIPE_DEPTH  = FRAC + 26;
   localparam int     HOLD_CYCLES = 200;
   localparam int     STALL_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bcr_req_if req_bus ();
   bcr_rsp_if rsp_bus ();

   bilinear_channel_resampler u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   logic [SRC_SIDE_W-1:0] src_width_reg;
   logic [SRC_SIDE_W-1:0] src_height_reg;
   logic [TGT_SIDE_W-1:0] dst_width_reg;
   logic [TGT_SIDE_W-1:0] dst_height_reg;
   logic                  round_reg;

   bit [7:0]    source_texels [0:SIDE*SIDE-1];
   bit          texel_known [0:SIDE*SIDE-1];
   logic [7:0]  expected_samples [$];
   int          error_count;
   int          words_sent;
   bit          sender_gaps;
   bit          receiver_gaps;
   bit          hold_results;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint usable_side(input longint setting);
      if (setting < 1) return 1;
      if (setting > SIDE) return SIDE;
      return setting;
   endfunction

   function automatic void locate_neighbours(input longint dest, input longint setting,
                                             input longint span, output longint lo,
                                             output longint hi, output longint frac);
      longint side, divisor, pos, whole;
      side    = usable_side(setting);
      divisor = (span >= 2) ? span - 1 : 1;
      pos     = ((dest * (side - 1)) << FRAC) / divisor;
      whole   = pos >> FRAC;
      frac    = pos & (ONE - 1);
      if (whole >= side - 1) begin
         lo = side - 1;
         hi = side - 1;
         if (whole > side - 1) frac = 0;
      end else begin
         lo = whole;
         hi = whole + 1;
      end
   endfunction

   function automatic logic [7:0] interpolate_sample(input longint dx, input longint dy);
      longint x0, x1, fx, y0, y1, fy;
      longint t00, t10, t01, t11, top, bottom, mix;
      locate_neighbours(dx, src_width_reg, dst_width_reg, x0, x1, fx);
      locate_neighbours(dy, src_height_reg, dst_height_reg, y0, y1, fy);
      t00    = source_texels[y0 * SIDE + x0];
      t10    = source_texels[y0 * SIDE + x1];
      t01    = source_texels[y1 * SIDE + x0];
      t11    = source_texels[y1 * SIDE + x1];
      top    = t00 * ONE + (t10 - t00) * fx;
      bottom = t01 * ONE + (t11 - t01) * fx;
      mix    = top * ONE + (bottom - top) * fy;
      if (mix < 0) mix = 0;
      if (round_reg) mix += longint'(1) << (2 * FRAC - 1);
      mix = mix >> (2 * FRAC);
      if (mix > 255) mix = 255;
      return mix[7:0];
   endfunction

   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
   endfunction

   function automatic logic [11:0] pick_coord(input longint limit);
      int k;
      k = $urandom_range(0, 9);
      if (k < 7) return 12'($urandom_range(0, int'(limit)));
      if (k < 8) return 12'(limit);
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic logic [12:0] pick_source_side();
      int k;
      k = $urandom_range(0, 19);
      if (k < 12) return 13'($urandom_range(2, 8));
      if (k < 16) return 13'($urandom_range(9, 256));
      if (k == 16) return 13'd256;
      if (k == 17) return 13'($urandom_range(0, 1));
      return 13'($urandom_range(257, 8191));
   endfunction

   function automatic logic [12:0] pick_target_side();
      int k;
      k = $urandom_range(0, 19);
      if (k < 12) return 13'($urandom_range(2, 16));
      if (k < 16) return 13'($urandom_range(17, 4096));
      if (k == 16) return 13'd4096;
      if (k == 17) return 13'($urandom_range(0, 1));
      return 13'($urandom_range(4097, 8191));
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   // Leaves valid high after acceptance; the next word or wait_for_idle takes it over.
   task automatic send_word(input opcode_type op, input logic [11:0] x, input logic [11:0] y,
                            input logic [7:0] value);
      @(negedge clock);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle_length()) @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.pos_x  <= x;
      req_bus.pos_y  <= y;
      req_bus.texel  <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      words_sent++;
   endtask

   task automatic store_texel(input logic [11:0] x, input logic [11:0] y,
                              input logic [7:0] value);
      send_word(OP_WRITE, x, y, value);
      texel_known[y * SIDE + x] = 1'b1;
   endtask

   // Write any neighbour not yet stored, then ask for the pixel.
   task automatic sample_pixel(input logic [11:0] dx, input logic [11:0] dy);
      longint x0, x1, fx, y0, y1, fy, cx, cy;
      int n;
      locate_neighbours(dx, src_width_reg, dst_width_reg, x0, x1, fx);
      locate_neighbours(dy, src_height_reg, dst_height_reg, y0, y1, fy);
      for (n = 0; n < 4; n++) begin
         cx = n[0] ? x1 : x0;
         cy = n[1] ? y1 : y0;
         if (!texel_known[cy * SIDE + cx]) store_texel(12'(cx), 12'(cy), 8'($urandom));
      end
      send_word(OP_SAMPLE, dx, dy, 8'($urandom));
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic configure(input logic [12:0] sw, input logic [12:0] sh,
                            input logic [12:0] tw, input logic [12:0] th,
                            input logic [12:0] rn);
      logic [12:0]   values [5];
      csr_index_type order [5];
      int i;
      values = '{sw, sh, tw, th, rn};
      order  = '{CSR_SOURCE_WIDTH, CSR_SOURCE_HEIGHT, CSR_TARGET_WIDTH,
                 CSR_TARGET_HEIGHT, CSR_ROUND_NEAREST};
      for (i = 0; i < 5; i++) begin
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= values[i];
         @(posedge clock);
         case (order[i])
            CSR_SOURCE_WIDTH:  src_width_reg  = values[i][SRC_SIDE_W-1:0];
            CSR_SOURCE_HEIGHT: src_height_reg = values[i][SRC_SIDE_W-1:0];
            CSR_TARGET_WIDTH:  dst_width_reg  = values[i][TGT_SIDE_W-1:0];
            CSR_TARGET_HEIGHT: dst_height_reg = values[i][TGT_SIDE_W-1:0];
            default:           round_reg      = values[i][0];
         endcase
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_traffic(input int count);
      int stop_at, pick;
      longint side_x, side_y, lim_x, lim_y;
      stop_at = words_sent + count;
      side_x  = usable_side(src_width_reg);
      side_y  = usable_side(src_height_reg);
      lim_x   = (dst_width_reg >= 1) ? dst_width_reg - 1 : 0;
      lim_y   = (dst_height_reg >= 1) ? dst_height_reg - 1 : 0;
      if (lim_x > 4095) lim_x = 4095;
      if (lim_y > 4095) lim_y = 4095;
      while (words_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            sample_pixel(pick_coord(lim_x), pick_coord(lim_y));
         end else if (pick < 88) begin
            store_texel(12'($urandom_range(0, int'(side_x) - 1)),
                        12'($urandom_range(0, int'(side_y) - 1)), 8'($urandom));
         end else if (pick[0]) begin
            send_word(OP_WRITE, 12'($urandom_range(SIDE, 4095)), 12'($urandom_range(0, 4095)),
                      8'($urandom));
         end else begin
            send_word(OP_WRITE, 12'($urandom_range(0, 4095)), 12'($urandom_range(SIDE, 4095)),
                      8'($urandom));
         end
      end
   endtask

   task automatic test_reset_state();
      store_texel(12'd0, 12'd0, 8'hFF);
      store_texel(12'd255, 12'd255, 8'h00);
      send_word(OP_WRITE, 12'd256, 12'd0, 8'h00);
      send_word(OP_WRITE, 12'd0, 12'hFFF, 8'h00);
      sample_pixel(12'd0, 12'd0);
      sample_pixel(12'hFFF, 12'hFFF);
      wait_for_idle();
   endtask

   task automatic test_interpolation();
      configure(13'd2, 13'd2, 13'd5, 13'd5, 13'd0);
      store_texel(12'd0, 12'd0, 8'h00);
      store_texel(12'd1, 12'd0, 8'hFF);
      sample_pixel(12'd1, 12'd2);
      sample_pixel(12'd3, 12'd3);
      wait_for_idle();
      configure(13'd2, 13'd2, 13'd5, 13'd5, 13'd1);
      sample_pixel(12'd1, 12'd1);
      store_texel(12'd0, 12'd0, 8'hFF);
      store_texel(12'd1, 12'd0, 8'hFF);
      store_texel(12'd0, 12'd1, 8'hFF);
      store_texel(12'd1, 12'd1, 8'hFF);
      sample_pixel(12'd2, 12'd2);
      wait_for_idle();
   endtask

   task automatic test_size_limits();
      configure(13'd0, 13'd1, 13'd0, 13'd1, 13'd0);
      sample_pixel(12'd3, 12'd5);
      wait_for_idle();
      configure(13'h1FFF, 13'd257, 13'h1FFF, 13'd4096, 13'h1FFE);
      sample_pixel(12'hFFF, 12'd1);
      wait_for_idle();
   endtask

   task automatic test_full_rate();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      configure(13'd4, 13'd3, 13'd9, 13'd7, 13'd1);
      random_traffic(100);
      wait_for_idle();
   endtask

   task automatic test_backpressure();
      configure(13'd5, 13'd5, 13'd11, 13'd13, 13'd0);
      hold_results = 1'b1;
      random_traffic(80);
      wait_for_idle();
   endtask

   task automatic test_random_settings();
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         configure(pick_source_side(), pick_source_side(), pick_target_side(),
                   pick_target_side(), 13'($urandom_range(0, 8191)));
         sender_gaps   = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         random_traffic(110);
         wait_for_idle();
      end
   endtask

   initial begin : result_ready_driver
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_results = 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (idle_length() - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : request_monitor
      int x, y;
      x = req_bus.pos_x;
      y = req_bus.pos_y;
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
         if (opcode_type'(req_bus.opcode) == OP_WRITE) begin
            if (x < SIDE && y < SIDE) source_texels[y * SIDE + x] = req_bus.texel;
         end else begin
            expected_samples = {expected_samples, interpolate_sample(x, y)};
         end
      end
   end

   always @(posedge clock) begin : result_checker
      logic [7:0] want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d with none outstanding", rsp_bus.sample));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_bus.sample !== want)
               report_mismatch($sformatf("sample %0d, expected %0d", rsp_bus.sample, want));
         end
      end
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_bus.valid && req_bus.ready)
             || (rsp_bus.valid && rsp_bus.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_SOURCE_WIDTH;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.opcode = OP_WRITE;
      req_bus.pos_x  = '0;
      req_bus.pos_y  = '0;
      req_bus.texel  = '0;
      src_width_reg  = SOURCE_WIDTH_RESET;
      src_height_reg = SOURCE_HEIGHT_RESET;
      dst_width_reg  = TARGET_WIDTH_RESET;
      dst_height_reg = TARGET_HEIGHT_RESET;
      round_reg      = ROUND_NEAREST_RESET;
      error_count    = 0;
      words_sent     = 0;
      sender_gaps    = 1'b1;
      receiver_gaps  = 1'b1;
      hold_results   = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_interpolation();
      test_size_limits();
      test_full_rate();
      test_backpressure();
      test_random_settings();

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
